// File: hw/rtl/hsmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsmc_pkg
// Shared types and constants of the hard sphere move checker.
// ----------------------------------------------------------------------------
package hsmc_pkg;

   localparam int MAX_PARTICLES_DEF = 256;

   localparam int COORD_W = 24;
   localparam int RAD_W   = 17;
   localparam int RSUM_W  = 18;
   localparam int DIV_W   = 25;   // magnitude bits fed into the remainder chain
   localparam int CELLS   = 25;   // one remainder cell per magnitude bit
   localparam int DIST_W  = 25;   // signed minimum-image distance
   localparam int SQ_W    = 50;
   localparam int RS2_W   = 36;
   localparam int PEND_W  = 6;

   localparam logic [COORD_W-1:0] BOX_RESET   = 24'd655360;
   localparam logic [8:0]         COUNT_RESET = 9'd1;

   localparam logic MODE_DIFF = 1'b0;
   localparam logic MODE_WRAP = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MOVE  = 2'd1,
      OP_CHECK = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_BOX_LENGTH     = 1'b0,
      CSR_PARTICLE_COUNT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MCHK,
      ST_MWAIT,
      ST_SCAN,
      ST_GCHK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         particle_index;
      logic [23:0]        load_x;
      logic [23:0]        load_y;
      logic [23:0]        load_z;
      logic [16:0]        load_radius;
      logic signed [23:0] step_x;
      logic signed [23:0] step_y;
      logic signed [23:0] step_z;
   } req_type;

   typedef struct packed {
      logic [7:0]  echo_index;
      logic        move_accepted;
      logic        overlap_found;
      logic        range_error;
      logic [23:0] final_x;
      logic [23:0] final_y;
      logic [23:0] final_z;
   } rsp_type;

   // one axis inside the remainder chain
   typedef struct packed {
      logic [COORD_W-1:0] rem;
      logic [DIV_W-1:0]   divd;
      logic               neg;
      logic [DIST_W-1:0]  raw;
   } lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 mode;
      logic [RSUM_W-1:0]    rsum;
      lane_type [2:0]       lane;
   } cell_type;

   typedef struct packed {
      logic                      wrap_valid;
      logic [2:0][COORD_W-1:0]   wrap_c;
      logic                      pair_valid;
      logic                      pair_hit;
   } ovl_out_type;

endpackage
`default_nettype wire

// File: hw/rtl/hsmc_rem_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsmc_rem_cell
// One restoring-remainder step on three axes, registered.
// ----------------------------------------------------------------------------
module hsmc_rem_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [23:0]              box_length,
   input  hsmc_pkg::cell_type       din,
   output hsmc_pkg::cell_type       dout
);

   hsmc_pkg::cell_type dout_ff, dout_in;
   logic [24:0] trial [3];

   always_comb begin
      dout_in = din;
      for (int l = 0; l < 3; l++) begin
         trial[l] = {din.lane[l].rem, din.lane[l].divd[hsmc_pkg::DIV_W-1]};
         if (trial[l] >= {1'b0, box_length}) begin
            trial[l] = trial[l] - {1'b0, box_length};
         end
         dout_in.lane[l].rem  = trial[l][23:0];
         dout_in.lane[l].divd = {din.lane[l].divd[hsmc_pkg::DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff <= '0;
      end else begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule
`default_nettype wire

// File: hw/rtl/hsmc_rem_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsmc_rem_chain
// Row of remainder cells: reduces three magnitudes modulo the box length.
// ----------------------------------------------------------------------------
module hsmc_rem_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [23:0]              box_length,
   input  hsmc_pkg::cell_type       din,
   output hsmc_pkg::cell_type       dout
);

   hsmc_pkg::cell_type link [hsmc_pkg::CELLS+1];

   assign link[0] = din;

   for (genvar i = 0; i < hsmc_pkg::CELLS; i++) begin : g_cell
      hsmc_rem_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .box_length (box_length),
         .din        (link[i]),
         .dout       (link[i+1])
      );
   end

   assign dout = link[hsmc_pkg::CELLS];

endmodule
`default_nettype wire

// File: hw/rtl/hsmc_overlap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsmc_overlap
// Sign fix and minimum image, squares, sum and overlap compare.
// ----------------------------------------------------------------------------
module hsmc_overlap (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [23:0]              box_length,
   input  hsmc_pkg::cell_type       din,
   output hsmc_pkg::ovl_out_type    result
);

   logic [23:0]        mfix [3];
   logic               fix_valid_ff, fix_valid_in;
   logic               fix_mode_ff, fix_mode_in;
   logic [17:0]        fix_rsum_ff, fix_rsum_in;
   logic signed [24:0] fix_d_ff [3];
   logic signed [24:0] fix_d_in [3];
   logic [23:0]        fix_m_ff [3];
   logic [23:0]        fix_m_in [3];

   logic               sq_valid_ff, sq_valid_in;
   logic signed [49:0] sq_ff [3];
   logic signed [49:0] sq_in [3];
   logic [35:0]        rs2_ff, rs2_in;

   logic               sum_valid_ff, sum_valid_in;
   logic [49:0]        d2_ff, d2_in;
   logic [35:0]        rs2s_ff, rs2s_in;

   logic               cmp_valid_ff, cmp_valid_in;
   logic               hit_ff, hit_in;

   // remainder carries the sign of the difference; fold into (-L/2, L/2]
   always_comb begin
      fix_valid_in = din.valid;
      fix_mode_in  = din.mode;
      fix_rsum_in  = din.rsum;
      for (int l = 0; l < 3; l++) begin
         mfix[l] = din.lane[l].rem;
         if (din.lane[l].neg && (mfix[l] != 24'd0)) begin
            mfix[l] = box_length - mfix[l];
         end
         fix_m_in[l] = mfix[l];
         if (box_length == 24'd0) begin
            fix_d_in[l] = din.lane[l].raw;
         end else if ({mfix[l], 1'b0} > {1'b0, box_length}) begin
            fix_d_in[l] = {1'b0, mfix[l]} - {1'b0, box_length};
         end else begin
            fix_d_in[l] = {1'b0, mfix[l]};
         end
      end
   end

   always_comb begin
      sq_valid_in = fix_valid_ff && (fix_mode_ff == hsmc_pkg::MODE_DIFF);
      for (int l = 0; l < 3; l++) begin
         sq_in[l] = fix_d_ff[l] * fix_d_ff[l];
      end
      rs2_in = fix_rsum_ff * fix_rsum_ff;
   end

   always_comb begin
      sum_valid_in = sq_valid_ff;
      d2_in   = $unsigned(sq_ff[0]) + $unsigned(sq_ff[1]) + $unsigned(sq_ff[2]);
      rs2s_in = rs2_ff;
      cmp_valid_in = sum_valid_ff;
      hit_in       = d2_ff < {14'd0, rs2s_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         fix_valid_ff <= fix_valid_in;
         sq_valid_ff  <= sq_valid_in;
         sum_valid_ff <= sum_valid_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fix_mode_ff <= fix_mode_in;
      fix_rsum_ff <= fix_rsum_in;
      fix_d_ff    <= fix_d_in;
      fix_m_ff    <= fix_m_in;
      sq_ff       <= sq_in;
      rs2_ff      <= rs2_in;
      d2_ff       <= d2_in;
      rs2s_ff     <= rs2s_in;
      hit_ff      <= hit_in;
   end

   always_comb begin
      result.wrap_valid = fix_valid_ff && (fix_mode_ff == hsmc_pkg::MODE_WRAP);
      for (int l = 0; l < 3; l++) begin
         result.wrap_c[l] = fix_m_ff[l];
      end
      result.pair_valid = cmp_valid_ff;
      result.pair_hit   = hit_ff;
   end

endmodule
`default_nettype wire

// File: hw/rtl/hard_sphere_move_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hard_sphere_move_checker
// Hard sphere store in a periodic cubic box with move and overlap checks.
// ----------------------------------------------------------------------------
// Usage
//   req_* is a valid/ready channel carrying one request word (load, move,
//   global check). rsp_* returns exactly one result word per request. csr_*
//   writes box_length (index 0) and particle_count (index 1); write only idle.
// Throughput (one request in flight at a time)
//   move         : one stored particle is read per cycle from the second
//     memory port and streamed through the 25-cell remainder row (minimum
//     image), then the square/sum/compare stages. The wrap of the new spot
//     uses the same row.
//   global check : one pair per cycle from the two read ports.
// Reset
//   Control state is cleared and the CSRs load their reset values; the store is not
//   cleared, entries read before they are loaded are undefined.
// Stall
//   The result waits in the output register while rsp_ready is low. The
//   next request is still taken; its result then waits in DONE until the
//   output register has handed its word on.
// ----------------------------------------------------------------------------
module hard_sphere_move_checker #(
   parameter int MAX_PARTICLES = hsmc_pkg::MAX_PARTICLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hsmc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hsmc_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [23:0]         csr_wdata
);

   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int PW    = hsmc_pkg::PEND_W;

   // configuration
   logic [23:0]      box_ff, box_in;
   logic [8:0]       count_ff, count_in;
   logic [CNT_W-1:0] n_act;

   // sequencer
   hsmc_pkg::state_type state_ff, state_in;
   hsmc_pkg::req_type   req_ff, req_in;
   hsmc_pkg::rsp_type   res_ff, res_in;
   hsmc_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [23:0] cur_x_ff, cur_y_ff, cur_z_ff, cur_x_in, cur_y_in, cur_z_in;
   logic [16:0] cur_r_ff, cur_r_in;
   logic [23:0] new_x_ff, new_y_ff, new_z_ff, new_x_in, new_y_in, new_z_in;
   logic        ovl_ff, ovl_in;
   logic [PW-1:0]    pend_ff, pend_in;
   logic [IDX_W-1:0] j_ff, j_in, ga_ff, ga_in, gb_ff, gb_in;
   logic        issue_ff, issue_in, issue_move_ff, issue_move_in;

   // particle store
   logic [23:0] mem_x [MAX_PARTICLES];
   logic [23:0] mem_y [MAX_PARTICLES];
   logic [23:0] mem_z [MAX_PARTICLES];
   logic [16:0] mem_r [MAX_PARTICLES];
   logic [23:0] rda_x_ff, rda_y_ff, rda_z_ff, rdb_x_ff, rdb_y_ff, rdb_z_ff;
   logic [16:0] rda_r_ff, rdb_r_ff;

   logic             accept, out_free, idx_in_store, idx_active, rerr;
   logic             j_last, g_last, drain_done, wrap_inject;
   logic [IDX_W-1:0] idx_addr_in, idx_addr_ff;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [23:0]      wr_x, wr_y, wr_z;
   logic [16:0]      wr_r;
   logic [23:0]      a_x, a_y, a_z;
   logic [16:0]      a_r;

   hsmc_pkg::cell_type    chain_in, chain_out;
   hsmc_pkg::ovl_out_type ovl_out;

   function automatic logic [23:0] abs24(input logic [23:0] s);
      return s[23] ? (24'd0 - s) : s;
   endfunction

   // coordinate plus step, magnitude and sign for the remainder row
   function automatic hsmc_pkg::lane_type wrap_lane(input logic [23:0] c,
                                                    input logic [23:0] s);
      logic [25:0] v;
      logic [25:0] mag;
      hsmc_pkg::lane_type l;
      v   = {2'b00, c} + {{2{s[23]}}, s};
      mag = v[25] ? (26'd0 - v) : v;
      l.rem  = '0;
      l.divd = mag[24:0];
      l.neg  = v[25];
      l.raw  = v[24:0];
      return l;
   endfunction

   // raw difference a - b for the minimum image
   function automatic hsmc_pkg::lane_type diff_lane(input logic [23:0] a,
                                                    input logic [23:0] b);
      logic [24:0] d;
      hsmc_pkg::lane_type l;
      d = {1'b0, a} - {1'b0, b};
      l.rem  = '0;
      l.divd = d[24] ? (25'd0 - d) : d;
      l.neg  = d[24];
      l.raw  = d;
      return l;
   endfunction

   // ---- helpers --------------------------------------------------------
   always_comb begin
      if (32'(count_ff) > 32'(MAX_PARTICLES)) begin
         n_act = CNT_W'(MAX_PARTICLES);
      end else begin
         n_act = CNT_W'(count_ff);
      end
   end

   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign idx_in_store = 32'(req_data.particle_index) < 32'(MAX_PARTICLES);
   assign idx_active   = 32'(req_data.particle_index) < 32'(n_act);
   assign idx_addr_in  = IDX_W'(req_data.particle_index);
   assign idx_addr_ff  = IDX_W'(req_ff.particle_index);
   assign rerr = (abs24(req_ff.step_x) >= box_ff) || (abs24(req_ff.step_y) >= box_ff) ||
                 (abs24(req_ff.step_z) >= box_ff);
   assign j_last     = (32'(j_ff) + 32'd1) == 32'(n_act);
   assign g_last     = ((32'(gb_ff) + 32'd1) == 32'(ga_ff)) &&
                       ((32'(ga_ff) + 32'd1) == 32'(n_act));
   assign drain_done = !issue_ff && (pend_ff == '0);

   // ---- control outputs ------------------------------------------------
   always_comb begin
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      wr_addr       = idx_addr_ff;
      wr_x          = new_x_ff;
      wr_y          = new_y_ff;
      wr_z          = new_z_ff;
      wr_r          = cur_r_ff;
      rd_addr_a     = ga_ff;
      rd_addr_b     = gb_ff;
      wrap_inject   = 1'b0;
      issue_in      = 1'b0;
      issue_move_in = 1'b0;
      case (state_ff)
         hsmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr_a = idx_addr_in;
            if (accept && (req_data.opcode == hsmc_pkg::OP_LOAD) && idx_in_store) begin
               mem_we  = 1'b1;
               wr_addr = idx_addr_in;
               wr_x    = req_data.load_x;
               wr_y    = req_data.load_y;
               wr_z    = req_data.load_z;
               wr_r    = req_data.load_radius;
            end
         end
         hsmc_pkg::ST_MCHK: begin
            wrap_inject = !rerr;
         end
         hsmc_pkg::ST_SCAN: begin
            rd_addr_b     = j_ff;
            issue_in      = (j_ff != idx_addr_ff);
            issue_move_in = 1'b1;
         end
         hsmc_pkg::ST_GCHK: begin
            issue_in = 1'b1;
         end
         hsmc_pkg::ST_DRAIN: begin
            mem_we = drain_done && (req_ff.opcode == hsmc_pkg::OP_MOVE) && !ovl_ff;
         end
         default: begin
         end
      endcase
   end

   // ---- next state ----------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsmc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  hsmc_pkg::OP_MOVE:
                     state_in = idx_active ? hsmc_pkg::ST_MCHK : hsmc_pkg::ST_DONE;
                  hsmc_pkg::OP_CHECK:
                     state_in = (32'(n_act) < 32'd2) ? hsmc_pkg::ST_DRAIN
                                                     : hsmc_pkg::ST_GCHK;
                  default: state_in = hsmc_pkg::ST_DONE;
               endcase
            end
         end
         hsmc_pkg::ST_MCHK:  state_in = rerr ? hsmc_pkg::ST_DONE : hsmc_pkg::ST_MWAIT;
         hsmc_pkg::ST_MWAIT: begin
            if (ovl_out.wrap_valid) begin
               state_in = hsmc_pkg::ST_SCAN;
            end
         end
         hsmc_pkg::ST_SCAN: begin
            if (j_last) begin
               state_in = hsmc_pkg::ST_DRAIN;
            end
         end
         hsmc_pkg::ST_GCHK: begin
            if (g_last) begin
               state_in = hsmc_pkg::ST_DRAIN;
            end
         end
         hsmc_pkg::ST_DRAIN: begin
            if (drain_done) begin
               state_in = hsmc_pkg::ST_DONE;
            end
         end
         hsmc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = hsmc_pkg::ST_IDLE;
            end
         end
         default: state_in = hsmc_pkg::ST_IDLE;
      endcase
   end

   // ---- datapath next values -------------------------------------------
   always_comb begin
      box_in   = box_ff;
      count_in = count_ff;
      if (csr_we) begin
         case (csr_index)
            hsmc_pkg::CSR_BOX_LENGTH:     box_in   = csr_wdata;
            hsmc_pkg::CSR_PARTICLE_COUNT: count_in = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_in   = req_ff;
      res_in   = res_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_z_in = cur_z_ff;
      cur_r_in = cur_r_ff;
      new_x_in = new_x_ff;
      new_y_in = new_y_ff;
      new_z_in = new_z_ff;
      ovl_in   = ovl_ff;
      j_in     = j_ff;
      ga_in    = ga_ff;
      gb_in    = gb_ff;
      pend_in  = pend_ff + PW'(issue_ff) - PW'(ovl_out.pair_valid);
      if (ovl_out.pair_valid && ovl_out.pair_hit) begin
         ovl_in = 1'b1;
      end
      case (state_ff)
         hsmc_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '0;
               res_in.echo_index = req_data.particle_index;
               if ((req_data.opcode == hsmc_pkg::OP_LOAD) && idx_in_store) begin
                  res_in.final_x = req_data.load_x;
                  res_in.final_y = req_data.load_y;
                  res_in.final_z = req_data.load_z;
               end
               ovl_in = 1'b0;
               j_in   = '0;
               ga_in  = IDX_W'(1);
               gb_in  = '0;
            end
         end
         hsmc_pkg::ST_MCHK: begin
            cur_x_in = rda_x_ff;
            cur_y_in = rda_y_ff;
            cur_z_in = rda_z_ff;
            cur_r_in = rda_r_ff;
            if (rerr) begin
               res_in.range_error = 1'b1;
               res_in.final_x     = rda_x_ff;
               res_in.final_y     = rda_y_ff;
               res_in.final_z     = rda_z_ff;
            end
         end
         hsmc_pkg::ST_MWAIT: begin
            if (ovl_out.wrap_valid) begin
               new_x_in = ovl_out.wrap_c[0];
               new_y_in = ovl_out.wrap_c[1];
               new_z_in = ovl_out.wrap_c[2];
            end
         end
         hsmc_pkg::ST_SCAN: begin
            j_in = j_ff + IDX_W'(1);
         end
         hsmc_pkg::ST_GCHK: begin
            if ((32'(gb_ff) + 32'd1) == 32'(ga_ff)) begin
               ga_in = ga_ff + IDX_W'(1);
               gb_in = '0;
            end else begin
               gb_in = gb_ff + IDX_W'(1);
            end
         end
         hsmc_pkg::ST_DRAIN: begin
            if (drain_done) begin
               if (req_ff.opcode == hsmc_pkg::OP_MOVE) begin
                  if (ovl_ff) begin
                     res_in.overlap_found = 1'b1;
                     res_in.final_x       = cur_x_ff;
                     res_in.final_y       = cur_y_ff;
                     res_in.final_z       = cur_z_ff;
                  end else begin
                     res_in.move_accepted = 1'b1;
                     res_in.final_x       = new_x_ff;
                     res_in.final_y       = new_y_ff;
                     res_in.final_z       = new_z_ff;
                  end
               end else begin
                  res_in.overlap_found = ovl_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register: loaded from the finished result when the slot frees
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == hsmc_pkg::ST_DONE) && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // ---- pair feed into the remainder row ------------------------------
   always_comb begin
      a_x = issue_move_ff ? new_x_ff : rda_x_ff;
      a_y = issue_move_ff ? new_y_ff : rda_y_ff;
      a_z = issue_move_ff ? new_z_ff : rda_z_ff;
      a_r = issue_move_ff ? cur_r_ff : rda_r_ff;
      chain_in = '0;
      chain_in.mode = hsmc_pkg::MODE_DIFF;
      if (wrap_inject) begin
         chain_in.valid   = 1'b1;
         chain_in.mode    = hsmc_pkg::MODE_WRAP;
         chain_in.lane[0] = wrap_lane(rda_x_ff, req_ff.step_x);
         chain_in.lane[1] = wrap_lane(rda_y_ff, req_ff.step_y);
         chain_in.lane[2] = wrap_lane(rda_z_ff, req_ff.step_z);
      end else if (issue_ff) begin
         chain_in.valid   = 1'b1;
         chain_in.rsum    = {1'b0, a_r} + {1'b0, rdb_r_ff};
         chain_in.lane[0] = diff_lane(a_x, rdb_x_ff);
         chain_in.lane[1] = diff_lane(a_y, rdb_y_ff);
         chain_in.lane[2] = diff_lane(a_z, rdb_z_ff);
      end
   end

   hsmc_rem_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .box_length (box_ff),
      .din        (chain_in),
      .dout       (chain_out)
   );

   hsmc_overlap u_overlap (
      .clock      (clock),
      .reset      (reset),
      .box_length (box_ff),
      .din        (chain_out),
      .result     (ovl_out)
   );

   // ---- particle store: one write, two registered reads ------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
         mem_z[wr_addr] <= wr_z;
         mem_r[wr_addr] <= wr_r;
      end
      rda_x_ff <= mem_x[rd_addr_a];
      rda_y_ff <= mem_y[rd_addr_a];
      rda_z_ff <= mem_z[rd_addr_a];
      rda_r_ff <= mem_r[rd_addr_a];
      rdb_x_ff <= mem_x[rd_addr_b];
      rdb_y_ff <= mem_y[rd_addr_b];
      rdb_z_ff <= mem_z[rd_addr_b];
      rdb_r_ff <= mem_r[rd_addr_b];
   end

   // ---- registers ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsmc_pkg::ST_IDLE;
         box_ff       <= hsmc_pkg::BOX_RESET;
         count_ff     <= hsmc_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         pend_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         box_ff       <= box_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      cur_z_ff      <= cur_z_in;
      cur_r_ff      <= cur_r_in;
      new_x_ff      <= new_x_in;
      new_y_ff      <= new_y_in;
      new_z_ff      <= new_z_in;
      ovl_ff        <= ovl_in;
      j_ff          <= j_in;
      ga_ff         <= ga_in;
      gb_ff         <= gb_in;
      issue_move_ff <= issue_move_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions -----------------------------------------------------
   // a compare result never arrives without a pair in flight
   a_pend_nonzero: assert property (@(posedge clock) disable iff (reset)
      ovl_out.pair_valid |-> (pend_ff != '0))
      else $error("pair result with no pair outstanding");

   // the store is never written while it is being scanned
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == hsmc_pkg::ST_SCAN) || (state_ff == hsmc_pkg::ST_GCHK)) |-> !mem_we)
      else $error("store written during scan");

   // an accepted move carries no other flag
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.move_accepted &&
                      (rsp_data.overlap_found || rsp_data.range_error)))
      else $error("accepted move flagged");

   // the new spot is latched only while waiting for it
   a_wrap_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      ovl_out.wrap_valid |-> (state_ff == hsmc_pkg::ST_MWAIT))
      else $error("wrapped coordinate outside move wait");

endmodule
`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hard sphere move checker: loads, moves and
// global overlap checks under random idling, with a behavioural predictor
// of the particle store that produces the expected word for every request.
// ----------------------------------------------------------------------------
module tb;

   localparam int NSLOTS = 256;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   hsmc_pkg::req_type   req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   hsmc_pkg::rsp_type   rsp_data;
   logic                csr_we = 1'b0;
   logic [0:0]          csr_index = '0;
   logic [23:0]         csr_wdata = '0;

   hard_sphere_move_checker u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow of the particle store and registers
   logic [23:0] pos_x [NSLOTS];
   logic [23:0] pos_y [NSLOTS];
   logic [23:0] pos_z [NSLOTS];
   logic [16:0] rad   [NSLOTS];
   logic [23:0] box_len = hsmc_pkg::BOX_RESET;
   logic [8:0]  part_count = hsmc_pkg::COUNT_RESET;

   hsmc_pkg::rsp_type pending_words [$];
   int          mismatches = 0;
   bit          calm = 1'b0;       // no idling in the closing stretch
   int          hold_cycles = 0;   // long receiver hold-off, counted below

   function automatic int live_count();
      return (part_count > NSLOTS) ? NSLOTS : int'(part_count);
   endfunction

   // minimum image of a - b; raw difference when the box is zero
   function automatic longint min_image(longint a, longint b);
      longint d, len, m;
      d = a - b;
      len = longint'(box_len);
      if (len == 0) return d;
      m = d % len;
      if (m < 0) m += len;
      if (2 * m > len) m -= len;
      return m;
   endfunction

   function automatic bit spheres_hit(longint ax, longint ay, longint az, longint ar,
                                      longint bx, longint by, longint bz, longint br);
      longint dx, dy, dz, d2, rs;
      dx = min_image(ax, bx);
      dy = min_image(ay, by);
      dz = min_image(az, bz);
      d2 = dx * dx + dy * dy + dz * dz;
      rs = ar + br;
      return d2 < rs * rs;
   endfunction

   function automatic longint wrap_into_box(longint c, longint s);
      longint r;
      r = (c + s) % longint'(box_len);
      if (r < 0) r += longint'(box_len);
      return r;
   endfunction

   // expected word for one request; updates the shadow store
   function automatic hsmc_pkg::rsp_type predict_outcome(hsmc_pkg::req_type w);
      hsmc_pkg::rsp_type o;
      int      n, idx;
      longint  sx, sy, sz, len, nx, ny, nz;
      o = '0;
      n = live_count();
      idx = int'(w.particle_index);
      len = longint'(box_len);
      o.echo_index = w.particle_index;
      case (hsmc_pkg::op_type'(w.opcode))
         hsmc_pkg::OP_LOAD: begin
            pos_x[idx] = w.load_x;
            pos_y[idx] = w.load_y;
            pos_z[idx] = w.load_z;
            rad[idx]   = w.load_radius;
            o.final_x = w.load_x;
            o.final_y = w.load_y;
            o.final_z = w.load_z;
         end
         hsmc_pkg::OP_MOVE: begin
            if (idx < n) begin
               sx = longint'(w.step_x);
               sy = longint'(w.step_y);
               sz = longint'(w.step_z);
               o.final_x = pos_x[idx];
               o.final_y = pos_y[idx];
               o.final_z = pos_z[idx];
               if ((sx < 0 ? -sx : sx) >= len || (sy < 0 ? -sy : sy) >= len ||
                   (sz < 0 ? -sz : sz) >= len) begin
                  o.range_error = 1'b1;
               end else begin
                  nx = wrap_into_box(pos_x[idx], sx);
                  ny = wrap_into_box(pos_y[idx], sy);
                  nz = wrap_into_box(pos_z[idx], sz);
                  for (int j = 0; j < n && !o.overlap_found; j++)
                     if (j != idx && spheres_hit(nx, ny, nz, rad[idx],
                           pos_x[j], pos_y[j], pos_z[j], rad[j]))
                        o.overlap_found = 1'b1;
                  if (!o.overlap_found) begin
                     pos_x[idx] = nx[23:0];
                     pos_y[idx] = ny[23:0];
                     pos_z[idx] = nz[23:0];
                     o.move_accepted = 1'b1;
                     o.final_x = nx[23:0];
                     o.final_y = ny[23:0];
                     o.final_z = nz[23:0];
                  end
               end
            end
         end
         hsmc_pkg::OP_CHECK: begin
            for (int a = 1; a < n && !o.overlap_found; a++)
               for (int b = 0; b < a && !o.overlap_found; b++)
                  if (spheres_hit(pos_x[a], pos_y[a], pos_z[a], rad[a],
                                  pos_x[b], pos_y[b], pos_z[b], rad[b]))
                     o.overlap_found = 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------- sender
   // Valid is only lowered before a gap, so it never falls and rises in one step.
   task automatic send_word(hsmc_pkg::req_type w);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      pending_words.push_back(predict_outcome(w));
   endtask

   // sender stops, every outstanding word comes back, then a short quiet spell
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_words.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   // registers are only touched while the block is idle
   task automatic configure(logic [23:0] box, logic [8:0] count);
      drain();
      csr_we    <= 1'b1;
      csr_index <= hsmc_pkg::CSR_BOX_LENGTH;
      csr_wdata <= box;
      @(posedge clock);
      box_len = box;
      csr_index <= hsmc_pkg::CSR_PARTICLE_COUNT;
      csr_wdata <= 24'(count);
      @(posedge clock);
      part_count = count;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic hsmc_pkg::req_type mk_load(int idx, logic [23:0] x, logic [23:0] y,
                                                 logic [23:0] z, logic [16:0] r);
      hsmc_pkg::req_type w;
      w = '0;
      w.opcode = hsmc_pkg::OP_LOAD;
      w.particle_index = idx[7:0];
      w.load_x = x; w.load_y = y; w.load_z = z;
      w.load_radius = r;
      return w;
   endfunction

   function automatic hsmc_pkg::req_type mk_move(int idx, int sx, int sy, int sz);
      hsmc_pkg::req_type w;
      w = '0;
      w.opcode = hsmc_pkg::OP_MOVE;
      w.particle_index = idx[7:0];
      w.step_x = sx[23:0]; w.step_y = sy[23:0]; w.step_z = sz[23:0];
      return w;
   endfunction

   function automatic hsmc_pkg::req_type mk_check();
      hsmc_pkg::req_type w;
      w = '0;
      w.opcode = hsmc_pkg::OP_CHECK;
      w.particle_index = 8'($urandom);
      return w;
   endfunction

   function automatic logic [23:0] rand_coord();
      if (box_len == 0 || $urandom_range(0, 19) == 0) return 24'($urandom);
      return 24'($urandom_range(0, box_len - 1));
   endfunction

   function automatic int rand_step();
      int span;
      span = int'(box_len >> 3);
      case ($urandom_range(0, 19))
         0:       return int'($signed(24'($urandom)));
         1:       return ($urandom_range(0, 1) != 0) ? int'(box_len) : -int'(box_len);
         default: return int'($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   function automatic logic [16:0] rand_radius();
      if ($urandom_range(0, 9) == 0) return 17'($urandom);
      return 17'($urandom_range(0, 24000));
   endfunction

   // mostly well-formed moves of live particles, with loads, checks and unused opcodes mixed in
   function automatic hsmc_pkg::req_type rand_word();
      int n, sel, idx;
      hsmc_pkg::req_type w;
      n = live_count();
      sel = $urandom_range(0, 99);
      if (n > 0 && $urandom_range(0, 6) != 0) idx = $urandom_range(0, n - 1);
      else idx = $urandom_range(0, NSLOTS - 1);
      if (sel < 15) begin
         w = mk_load(idx, rand_coord(), rand_coord(), rand_coord(), rand_radius());
      end else if (sel < 90) begin
         w = mk_move(idx, rand_step(), rand_step(), rand_step());
      end else if (sel < 97 || n > 64) begin
         w = (n > 64) ? mk_move(idx, rand_step(), rand_step(), rand_step()) : mk_check();
      end else begin
         w = hsmc_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom});
         w.opcode = hsmc_pkg::OP_NONE;
      end
      return w;
   endfunction

   // ---------------------------------------------------------------- tests
   // Every slot is written first, so no scan ever reads an unloaded entry.
   task automatic test_fill_store();
      for (int i = 0; i < NSLOTS; i++)
         send_word(mk_load(i, 24'($urandom_range(0, 655359)),
                           24'($urandom_range(0, 655359)),
                           24'($urandom_range(0, 655359)), 17'($urandom_range(0, 20000))));
   endtask

   task automatic test_directed();
      hsmc_pkg::req_type w;
      // field extremes on load, one corner well outside the box
      send_word(mk_load(0, 24'd0, 24'd0, 24'd0, 17'd0));
      send_word(mk_load(255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'h1FFFF));
      // unused opcode with every bit set
      w = '1;
      w.opcode = hsmc_pkg::OP_NONE;
      send_word(w);
      // single live particle: move accepted, inactive index, step too large
      send_word(mk_move(0, 0, 0, 0));
      send_word(mk_move(0, 65536, -65536, 1));
      send_word(mk_move(1, 5, 5, 5));
      send_word(mk_move(0, 8388607, 0, 0));
      send_word(mk_move(0, 0, -8388608, 0));
      send_word(mk_move(0, 0, 0, 655360));
      send_word(mk_check());
      configure(hsmc_pkg::BOX_RESET, 9'd4);
      // half-box tie on x and a touching pair (distance equal to radius sum)
      send_word(mk_load(0, 24'd0, 24'd0, 24'd0, 17'd65536));
      send_word(mk_load(1, 24'd327680, 24'd0, 24'd0, 17'd65536));
      send_word(mk_load(2, 24'd0, 24'd131072, 24'd0, 17'd65536));
      send_word(mk_load(3, 24'd0, 24'd0, 24'd400000, 17'd1000));
      send_word(mk_check());
      send_word(mk_move(3, 0, 0, -300000));   // lands near 0 but clear of it
      send_word(mk_move(2, 0, -1, 0));        // closer than contact
      send_word(mk_move(1, -655359, 0, 0));   // wraps through zero
      send_word(mk_load(2, 24'd0, 24'd0, 24'd0, 17'd65536));
      send_word(mk_check());
   endtask

   task automatic test_count_extremes();
      configure(hsmc_pkg::BOX_RESET, 9'd0);
      send_word(mk_move(0, 10, 10, 10));
      send_word(mk_check());
      configure(24'd16777215, 9'd256);
      send_word(mk_move(255, 100, -100, 100));
      send_word(mk_check());
      configure(24'd16777215, 9'd511);       // saturates to the full store
      send_word(mk_move(255, -8388608, 8388607, 0));
      send_word(mk_move(7, 1000, 1000, 1000));
      send_word(mk_check());
   endtask

   task automatic test_box_extremes();
      configure(24'd0, 9'd6);                // every move of a live particle out of range
      for (int i = 0; i < 8; i++) send_word(rand_word());
      send_word(mk_move(2, 0, 0, 0));
      send_word(mk_check());
      configure(24'd65536, 9'd3);
      for (int i = 0; i < 3; i++)
         send_word(mk_load(i, 24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
                           24'($urandom_range(0, 65535)), 17'($urandom_range(0, 8000))));
      for (int i = 0; i < 20; i++) send_word(rand_word());
   endtask

   task automatic test_random_phases();
      logic [23:0] boxes [8] = '{24'd655360, 24'd327680, 24'd1310720, 24'd65536,
                                 24'd16777215, 24'd200000, 24'd655360, 24'd3000000};
      logic [8:0]  counts [8] = '{9'd8, 9'd3, 9'd16, 9'd2, 9'd40, 9'd5, 9'd256, 9'd12};
      int          nitems [8] = '{220, 200, 220, 150, 200, 200, 60, 220};
      for (int p = 0; p < 8; p++) begin
         configure(boxes[p], counts[p]);
         for (int i = 0; i < nitems[p]; i++) send_word(rand_word());
      end
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      configure(24'd655360, 9'd4);
      hold_cycles = 300;
      for (int i = 0; i < 6; i++) send_word(rand_word());
   endtask

   task automatic test_calm_tail();
      calm = 1'b1;
      for (int i = 0; i < 120; i++) send_word(rand_word());
   endtask

   // -------------------------------------------------------------- receiver
   always @(posedge clock) begin
      hsmc_pkg::rsp_type want;
      int      stall_left;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", rsp_data);
            end else begin
               want = pending_words.pop_front();
               if (rsp_data.echo_index !== want.echo_index ||
                   rsp_data.move_accepted !== want.move_accepted ||
                   rsp_data.overlap_found !== want.overlap_found ||
                   rsp_data.range_error !== want.range_error ||
                   rsp_data.final_x !== want.final_x ||
                   rsp_data.final_y !== want.final_y ||
                   rsp_data.final_z !== want.final_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word mismatch: expected %h got %h", want, rsp_data);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------ main
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_store();
      test_directed();
      test_count_extremes();
      test_box_extremes();
      test_random_phases();
      test_backpressure();
      test_calm_tail();
      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #(20 * 4000000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
